[rtl/grayscale_dilate_3x3_macros.svh]
// ---------------------------------------------------------------------------
// grayscale_dilate_3x3 assertion macros
// Concurrent checks on the rising edge of clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRAYSCALE_DILATE_3X3_MACROS_SVH
`define GRAYSCALE_DILATE_3X3_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define GD3_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GD3_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GD3_CHECK(lbl, ante, cons, msg)
`define GD3_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/gd3_pkg.sv]
// ---------------------------------------------------------------------------
// gd3_pkg
// Shared types and constants of the 3x3 grayscale dilation block.
// ---------------------------------------------------------------------------
package gd3_pkg;

  localparam int PIX_W     = 8;
  localparam int MAX_RES   = 4;   // results one input can release
  localparam int RES_CNT_W = 3;
  localparam int QDEPTH    = 4;   // result batches held by the output queue
  localparam int QPTR_W    = 2;
  localparam int LVL_W     = 3;

  localparam int FW_W = 12;
  localparam int FH_W = 16;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // Position flags of one pixel, worked out when it is taken in.
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic last_row;
    logic col_first;
    logic col_last;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] n;
  } batch_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/grayscale_dilate_3x3.sv]
// Timing: a taken pixel is registered in stage one and its results into the output queue;
// a frame's first result comes one row and one pixel after its input. Throughput: one pixel
// per cycle, but a row end releases up to two results and a last-row pixel up to two (four
// at the end of the last row), drained at one per cycle while out_stall is low by a
// four-batch output queue that stalls the input once full, in-flight included. Reset clears
// counters, windows and the queue and sets 640 x 480, but not the line stores.
// ---------------------------------------------------------------------------
// grayscale_dilate_3x3
// Streaming 3x3 grayscale dilation with edge replication, built around two
// line-store RAMs that hold the previous two rows.
// ---------------------------------------------------------------------------
`include "grayscale_dilate_3x3_macros.svh"

module grayscale_dilate_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gd3_pkg::FH_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [gd3_pkg::PIX_W-1:0] in_pixel_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gd3_pkg::PIX_W-1:0] out_pixel_out,
  output logic                      out_row_end,
  output logic                      out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > gd3_pkg::FW_W) ? WW : gd3_pkg::FW_W;
  localparam int HW = gd3_pkg::FH_W;

  logic [gd3_pkg::FW_W-1:0] frame_width_r;
  logic [HW-1:0]            frame_height_r;

  logic [CW-1:0]            col_r, col_nxt;
  logic [HW-1:0]            row_r, row_nxt;
  logic [XW-1:0]            w_eff, fw_ext;
  logic [HW-1:0]            h_eff;
  logic                     col_wrap;
  logic [CW-1:0]            c;
  logic [HW:0]              r_inc;
  logic [HW-1:0]            r;
  gd3_pkg::pos_t            pos;
  logic                     accept;

  logic                      s1_valid_r;
  logic [gd3_pkg::PIX_W-1:0] s1_cur_r;
  logic [CW-1:0]             s1_col_r;
  gd3_pkg::pos_t             s1_pos_r;
  logic                      fwd_r;
  logic [gd3_pkg::PIX_W-1:0] fwd_lower_r, fwd_upper_r;
  logic [gd3_pkg::PIX_W-1:0] upper_rdata, lower_rdata, mid, top;

  gd3_pkg::batch_t           batch;
  logic [gd3_pkg::LVL_W-1:0] level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gd3_pkg::FW_W'(640);
      frame_height_r <= HW'(480);
    end else if (cfg_we) begin
      unique case (gd3_pkg::cfg_idx_t'(cfg_index))
        gd3_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[gd3_pkg::FW_W-1:0];
        gd3_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel, after any wrap caused by a smaller bound.
  always_comb begin
    fw_ext = XW'(frame_width_r);
    if (fw_ext > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else if (fw_ext == '0) begin
      w_eff = XW'(1);
    end else begin
      w_eff = fw_ext;
    end
    h_eff    = (frame_height_r == '0) ? HW'(1) : frame_height_r;
    col_wrap = (XW'(col_r) >= w_eff);
    c        = col_wrap ? '0 : col_r;
    r_inc    = col_wrap ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    r        = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HW-1:0];

    pos.row_ge1   = (r != '0);
    pos.row_ge2   = (r >= HW'(2));
    pos.last_row  = (r == h_eff - 1'b1);
    pos.col_first = (c == '0);
    pos.col_last  = (XW'(c) == w_eff - 1'b1);

    if (pos.col_last) begin
      col_nxt = '0;
      row_nxt = pos.last_row ? '0 : r + 1'b1;
    end else begin
      col_nxt = c + 1'b1;
      row_nxt = r;
    end
  end

  // Room for this pixel's batch and for the one still being worked out.
  assign in_stall = ((gd3_pkg::LVL_W+1)'(level) + (gd3_pkg::LVL_W+1)'(s1_valid_r))
                    >= (gd3_pkg::LVL_W+1)'(gd3_pkg::QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // The previous pixel writes its column back in the cycle this one reads;
  // with a one-pixel row that is the same entry, so its values are forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r    <= in_pixel_in;
      s1_col_r    <= c;
      s1_pos_r    <= pos;
      fwd_r       <= s1_valid_r && (s1_col_r == c);
      fwd_lower_r <= s1_cur_r;
      fwd_upper_r <= mid;
    end
  end

  assign mid = fwd_r ? fwd_lower_r : lower_rdata;
  assign top = fwd_r ? fwd_upper_r : upper_rdata;

  gd3_ram #(
    .DATA_W (gd3_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (mid),
    .raddr (c),
    .rdata (upper_rdata)
  );

  gd3_ram #(
    .DATA_W (gd3_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_lower (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_cur_r),
    .raddr (c),
    .rdata (lower_rdata)
  );

  gd3_win u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_valid_r),
    .cur   (s1_cur_r),
    .mid   (mid),
    .top   (top),
    .pos   (s1_pos_r),
    .batch (batch)
  );

  gd3_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .batch         (batch),
    .level         (level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  `GD3_CHECK(a_queue_bound, 1'b1, level <= gd3_pkg::LVL_W'(gd3_pkg::QDEPTH), "output queue overflow")
  `GD3_CHECK_NEXT(a_accept_work, rst_n && accept, s1_valid_r, "accepted pixel not processed")
  `GD3_CHECK(a_no_phantom, !s1_valid_r, batch.n == '0, "results released without a pixel")

endmodule

[rtl/gd3_ram.sv]
// ---------------------------------------------------------------------------
// gd3_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module gd3_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/gd3_win.sv]
// ---------------------------------------------------------------------------
// gd3_win
// Column-maximum windows for the row above and the last row, and the
// batch of results that one pixel releases.
// ---------------------------------------------------------------------------
module gd3_win (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [gd3_pkg::PIX_W-1:0] cur,
  input  logic [gd3_pkg::PIX_W-1:0] mid,
  input  logic [gd3_pkg::PIX_W-1:0] top,
  input  gd3_pkg::pos_t             pos,
  output gd3_pkg::batch_t           batch
);

  logic [2:0][gd3_pkg::PIX_W-1:0] win_a_r, win_a_nxt;
  logic [2:0][gd3_pkg::PIX_W-1:0] win_b_r, win_b_nxt;
  logic [gd3_pkg::PIX_W-1:0]      cm_a, cm_b;
  logic                           rel_a, rel_b;
  gd3_pkg::res_t [3:0]            slot;
  logic [3:0]                     slot_v;

  assign rel_a = en && pos.row_ge1;
  assign rel_b = en && pos.last_row;

  assign cm_a = gd3_pkg::max2(gd3_pkg::max2(pos.row_ge2 ? top : mid, mid), cur);
  assign cm_b = gd3_pkg::max2(pos.row_ge1 ? mid : cur, cur);

  // At the first column the left edge is replicated across the window.
  always_comb begin
    win_a_nxt = win_a_r;
    win_b_nxt = win_b_r;
    if (rel_a) begin
      if (pos.col_first) begin
        win_a_nxt = {cm_a, cm_a, cm_a};
      end else begin
        win_a_nxt = {cm_a, win_a_r[2], win_a_r[1]};
      end
    end
    if (rel_b) begin
      if (pos.col_first) begin
        win_b_nxt = {cm_b, cm_b, cm_b};
      end else begin
        win_b_nxt = {cm_b, win_b_r[2], win_b_r[1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_a_r <= '0;
      win_b_r <= '0;
    end else begin
      win_a_r <= win_a_nxt;
      win_b_r <= win_b_nxt;
    end
  end

  // Index 0 is the oldest column, index 2 the newest.
  always_comb begin
    slot[0].pix = gd3_pkg::max2(gd3_pkg::max2(win_a_nxt[0], win_a_nxt[1]), win_a_nxt[2]);
    slot[0].row_end   = 1'b0;
    slot[0].frame_end = 1'b0;
    slot[1].pix       = gd3_pkg::max2(win_a_nxt[1], win_a_nxt[2]);
    slot[1].row_end   = 1'b1;
    slot[1].frame_end = 1'b0;
    slot[2].pix = gd3_pkg::max2(gd3_pkg::max2(win_b_nxt[0], win_b_nxt[1]), win_b_nxt[2]);
    slot[2].row_end   = 1'b0;
    slot[2].frame_end = 1'b0;
    slot[3].pix       = gd3_pkg::max2(win_b_nxt[1], win_b_nxt[2]);
    slot[3].row_end   = 1'b1;
    slot[3].frame_end = 1'b1;
    slot_v[0] = rel_a && !pos.col_first;
    slot_v[1] = rel_a && pos.col_last;
    slot_v[2] = rel_b && !pos.col_first;
    slot_v[3] = rel_b && pos.col_last;
  end

  // Pack the released results in order, the row above first.
  always_comb begin
    logic [gd3_pkg::RES_CNT_W-1:0] idx;
    idx   = '0;
    batch = '0;
    for (int i = 0; i < gd3_pkg::MAX_RES; i++) begin
      if (slot_v[i]) begin
        batch.res[idx[1:0]] = slot[i];
        idx = idx + 1'b1;
      end
    end
    batch.n = idx;
  end

endmodule

[rtl/gd3_outq.sv]
// ---------------------------------------------------------------------------
// gd3_outq
// Queue of result batches; hands results out one transfer at a time.
// ---------------------------------------------------------------------------
module gd3_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gd3_pkg::batch_t           batch,
  output logic [gd3_pkg::LVL_W-1:0] level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gd3_pkg::PIX_W-1:0] out_pixel_out,
  output logic                      out_row_end,
  output logic                      out_frame_end
);

  gd3_pkg::batch_t                rows_r [gd3_pkg::QDEPTH];
  logic [gd3_pkg::QPTR_W-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [gd3_pkg::LVL_W-1:0]      level_r, level_nxt;
  logic [1:0]                     sub_r, sub_nxt;
  gd3_pkg::batch_t                head;
  gd3_pkg::res_t                  head_res;
  logic                           push, pop, pop_last;

  assign head      = rows_r[rp_r];
  assign head_res  = head.res[sub_r];
  assign out_valid = (level_r != '0);
  assign out_pixel_out = head_res.pix;
  assign out_row_end   = head_res.row_end;
  assign out_frame_end = head_res.frame_end;
  assign level     = level_r;

  assign push     = (batch.n != '0);
  assign pop      = out_valid && !out_stall;
  assign pop_last = pop && (sub_r == 2'(head.n - 1'b1));

  always_comb begin
    wp_nxt    = push ? wp_r + 1'b1 : wp_r;
    rp_nxt    = pop_last ? rp_r + 1'b1 : rp_r;
    sub_nxt   = pop_last ? 2'd0 : (pop ? sub_r + 1'b1 : sub_r);
    level_nxt = level_r + gd3_pkg::LVL_W'(push) - gd3_pkg::LVL_W'(pop_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      sub_r   <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      sub_r   <= sub_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rows_r[wp_r] <= batch;
    end
  end

endmodule
